// File: rtl/pli_pkg.sv
// shared types, constants and codes of the posting list intersection core
`default_nettype none
package pli_pkg;

  localparam int MAX_LISTS_DEF  = 4;
  localparam int LIST_DEPTH_DEF = 64;

  localparam int DOC_W       = 32;
  localparam int SCORE_W     = 16;
  localparam int SUM_W       = 18;
  localparam int LCOUNT_W    = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [SUM_W-1:0] SCORE_MAX = {SUM_W{1'b1}};

  // register word index, paddr[2]
  localparam logic [0:0] REG_LIST_COUNT = 1'b0;
  localparam logic [LCOUNT_W-1:0] LIST_COUNT_RESET = 3'd2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_RUN    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         list_index;
    logic [DOC_W-1:0]   doc_number;
    logic [SCORE_W-1:0] posting_score;
    logic [DOC_W-1:0]   start_doc;
  } in_item_t;

  typedef struct packed {
    logic [DOC_W-1:0] match_doc;
    logic [SUM_W-1:0] match_score;
    logic             last;
    logic             none_found;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/posting_list_intersection_core.sv
// posting list intersection core: posting store, leap-frog walker and config port
`default_nettype none
// Holds MAX_LISTS strictly ascending posting lists of up to LIST_DEPTH postings
// each in one posting ram (document number and u8.8 score per entry). An append
// or a clear beat is taken in the idle state. A run beat walks the cursors of
// the first list_count lists (zero counts as one, capped at MAX_LISTS): every
// look at a cursor position is a ram read state then a compare state (a list's
// current posting is looked at again each time the walk comes back to it), a
// match passes through an emit state, and the check that finds a list exhausted
// leads to a finish state that sends the final result; emit and finish can wait
// on out_ready. No new beat is taken until a run has moved its final result into
// the output register. The ram needs no clearing pass: the list lengths, cleared
// at reset and by a clear beat, bound every read.
module posting_list_intersection_core
  import pli_pkg::*;
#(
  parameter int MAX_LISTS  = MAX_LISTS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int LW    = $clog2(MAX_LISTS);
  localparam int KW    = $clog2(MAX_LISTS + 1);
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int DEPTH = MAX_LISTS * LIST_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = SCORE_W + $clog2(MAX_LISTS);
  localparam int RW    = DOC_W + SCORE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK_RD,
    ST_SEEK_CHK,
    ST_EMIT,
    ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [LCOUNT_W-1:0] list_count_r, list_count_nxt;
  logic [CW-1:0]       len_r [MAX_LISTS];
  logic [CW-1:0]       len_nxt [MAX_LISTS];
  logic [CW-1:0]       cur_r [MAX_LISTS];
  logic [CW-1:0]       cur_nxt [MAX_LISTS];
  logic [DOC_W-1:0]    last_doc_r [MAX_LISTS];
  logic [KW-1:0]       k_r, k_nxt;
  logic [DOC_W:0]      tgt_r, tgt_nxt;
  logic [SW-1:0]       acc_r, acc_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [DOC_W-1:0]    pend_doc_r, pend_doc_nxt;
  logic [SUM_W-1:0]    pend_score_r, pend_score_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [KW-1:0]      n_lists;
  logic [LW-1:0]      k_idx;
  logic [LW-1:0]      li_idx;
  logic               li_ok;
  logic               in_fire;
  logic               slot_free;
  logic               push;
  out_item_t          push_data;
  logic               app_ok;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [RW-1:0]      ram_rdata;
  logic [DOC_W-1:0]   rd_doc;
  logic [SCORE_W-1:0] rd_score;
  logic [SW-1:0]      sum_now;
  logic [SUM_W-1:0]   sum_sat;
  logic               cfg_wr;

  // effective list count: zero counts as one, beyond the store saturates
  always_comb begin
    if (list_count_r == '0) begin
      n_lists = KW'(1);
    end else if (32'(list_count_r) > MAX_LISTS) begin
      n_lists = KW'(MAX_LISTS);
    end else begin
      n_lists = KW'(list_count_r);
    end
  end

  assign k_idx   = k_r[LW-1:0];
  assign li_idx  = LW'(in_data.list_index);
  assign li_ok   = 32'(in_data.list_index) < MAX_LISTS;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign app_ok = in_fire && (in_data.operation == OP_APPEND) && li_ok &&
                  (32'(len_r[li_idx]) < LIST_DEPTH) &&
                  ((len_r[li_idx] == '0) || (last_doc_r[li_idx] < in_data.doc_number));
  assign ram_we    = app_ok;
  assign ram_waddr = AW'(li_idx) * AW'(LIST_DEPTH) + AW'(len_r[li_idx]);
  assign ram_raddr = AW'(k_idx) * AW'(LIST_DEPTH) + AW'(cur_r[k_idx]);

  assign rd_doc   = ram_rdata[RW-1:SCORE_W];
  assign rd_score = ram_rdata[SCORE_W-1:0];

  assign sum_now = acc_r;
  assign sum_sat = (32'(sum_now) > 32'(SCORE_MAX)) ? SCORE_MAX : SUM_W'(sum_now);

  pli_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_post_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_data.doc_number, in_data.posting_score}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign list_count_nxt = (cfg_wr && paddr[2:2] == REG_LIST_COUNT) ?
                          pwdata[LCOUNT_W-1:0] : list_count_r;
  assign prdata = (paddr[2:2] == REG_LIST_COUNT) ?
                  CFG_DATA_W'(list_count_r) : '0;

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    cur_nxt        = cur_r;
    k_nxt          = k_r;
    tgt_nxt        = tgt_r;
    acc_nxt        = acc_r;
    pend_valid_nxt = pend_valid_r;
    pend_doc_nxt   = pend_doc_r;
    pend_score_nxt = pend_score_r;
    push           = 1'b0;
    push_data      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.operation)
            OP_APPEND: begin
              if (app_ok) begin
                len_nxt[li_idx] = len_r[li_idx] + CW'(1);
              end
            end
            OP_RUN: begin
              for (int i = 0; i < MAX_LISTS; i++) begin
                if (i < 32'(n_lists)) begin
                  cur_nxt[i] = '0;
                end
              end
              k_nxt     = '0;
              tgt_nxt   = {1'b0, in_data.start_doc};
              state_nxt = ST_SEEK_RD;
            end
            OP_CLEAR: begin
              for (int i = 0; i < MAX_LISTS; i++) begin
                len_nxt[i] = '0;
                cur_nxt[i] = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEEK_RD: begin
        // the ram is addressed by k and its cursor; data comes back next cycle
        if (cur_r[k_idx] == len_r[k_idx]) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SEEK_CHK;
        end
      end
      ST_SEEK_CHK: begin
        if ({1'b0, rd_doc} < tgt_r) begin
          cur_nxt[k_idx] = cur_r[k_idx] + CW'(1);
          state_nxt      = ST_SEEK_RD;
        end else if (k_r == '0) begin
          // lead list sets a new candidate
          tgt_nxt = {1'b0, rd_doc};
          acc_nxt = SW'(rd_score);
          if (n_lists == KW'(1)) begin
            state_nxt = ST_EMIT;
          end else begin
            k_nxt     = KW'(1);
            state_nxt = ST_SEEK_RD;
          end
        end else if ({1'b0, rd_doc} == tgt_r) begin
          acc_nxt = acc_r + SW'(rd_score);
          if (k_r + KW'(1) == n_lists) begin
            state_nxt = ST_EMIT;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = ST_SEEK_RD;
          end
        end else begin
          // follower overshot: leap the lead list forward
          tgt_nxt   = {1'b0, rd_doc};
          k_nxt     = '0;
          state_nxt = ST_SEEK_RD;
        end
      end
      ST_EMIT: begin
        // held one match back so the final one can carry last
        if (!pend_valid_r || slot_free) begin
          if (pend_valid_r) begin
            push      = 1'b1;
            push_data = '{match_doc: pend_doc_r, match_score: pend_score_r,
                          last: 1'b0, none_found: 1'b0};
          end
          pend_valid_nxt = 1'b1;
          pend_doc_nxt   = tgt_r[DOC_W-1:0];
          pend_score_nxt = sum_sat;
          tgt_nxt        = tgt_r + (DOC_W + 1)'(1);
          k_nxt          = '0;
          state_nxt      = ST_SEEK_RD;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          push = 1'b1;
          if (pend_valid_r) begin
            push_data = '{match_doc: pend_doc_r, match_score: pend_score_r,
                          last: 1'b1, none_found: 1'b0};
          end else begin
            push_data = '{match_doc: '0, match_score: '0,
                          last: 1'b1, none_found: 1'b1};
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      list_count_r <= LIST_COUNT_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
      k_r          <= '0;
      for (int i = 0; i < MAX_LISTS; i++) begin
        len_r[i] <= '0;
        cur_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      list_count_r <= list_count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
      k_r          <= k_nxt;
      len_r        <= len_nxt;
      cur_r        <= cur_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    tgt_r        <= tgt_nxt;
    acc_r        <= acc_nxt;
    pend_doc_r   <= pend_doc_nxt;
    pend_score_r <= pend_score_nxt;
    if (app_ok) begin
      last_doc_r[li_idx] <= in_data.doc_number;
    end
  end

`ifndef ASSERT_OFF
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEEK_RD || state_r == ST_SEEK_CHK) |-> (k_r < n_lists))
    else $error("walker list index beyond list count");

  a_read_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEEK_CHK) |-> (cur_r[k_idx] < len_r[k_idx]))
    else $error("posting read beyond list length");

  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.operation == OP_RUN) |=> !in_ready)
    else $error("run beat did not block the input");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.none_found) |-> out_data.last)
    else $error("empty result without last");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("held match left behind after a run");
`endif

endmodule
`default_nettype wire

// File: rtl/pli_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module pli_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: bench/tb.sv
// testbench for the posting list intersection core: directed and random beats, scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam int MAX_LISTS = MAX_LISTS_DEF;
  localparam int LIST_DEPTH = LIST_DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] LIST_COUNT_ADDR = {REG_LIST_COUNT, 2'b00};
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [32:0] DOC_TOP = 33'h0_FFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // shadow of the posting store and the register
  logic [DOC_W-1:0] doc_mem [MAX_LISTS][LIST_DEPTH];
  logic [SCORE_W-1:0] score_mem [MAX_LISTS][LIST_DEPTH];
  int unsigned list_len [MAX_LISTS];
  int unsigned cursor [MAX_LISTS];
  logic [LCOUNT_W-1:0] list_count_cfg;

  out_item_t expected_matches[$];
  out_item_t oldest_match;

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int beats_in;
  int counted_beats;
  int beats_out;
  int intersections;
  int reg_writes;
  int stall_cycles;

  posting_list_intersection_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // move the cursor of list k to the first document at or above target
  function automatic bit advance(int unsigned k, logic [32:0] target);
    while (cursor[k] < list_len[k] && {1'b0, doc_mem[k][cursor[k]]} < target)
      cursor[k]++;
    return cursor[k] < list_len[k];
  endfunction

  function automatic void predict_intersection(logic [DOC_W-1:0] start);
    int unsigned n;
    int unsigned found;
    int sum;
    logic [32:0] t;
    bit all_hit;
    bit finished;
    bit have_held;
    out_item_t held;
    n = list_count_cfg;
    if (n == 0) n = 1;
    if (n > MAX_LISTS) n = MAX_LISTS;
    for (int unsigned i = 0; i < n; i++) cursor[i] = 0;
    found = 0;
    have_held = 0;
    held = '0;
    if (advance(0, {1'b0, start})) begin
      while (1'b1) begin
        t = {1'b0, doc_mem[0][cursor[0]]};
        all_hit = 1;
        finished = 0;
        for (int unsigned i = 1; i < n; i++) begin
          if (!advance(i, t)) begin
            finished = 1;
            break;
          end
          if ({1'b0, doc_mem[i][cursor[i]]} != t) begin
            // leap the lead list up to the larger document
            if (!advance(0, {1'b0, doc_mem[i][cursor[i]]})) finished = 1;
            all_hit = 0;
            break;
          end
        end
        if (finished) break;
        if (all_hit) begin
          sum = 0;
          for (int unsigned i = 0; i < n; i++) sum += score_mem[i][cursor[i]];
          if (sum > SCORE_MAX) sum = SCORE_MAX;
          if (found < LIST_DEPTH) begin
            if (have_held) expected_matches.push_back(held);
            held.match_doc = t[DOC_W-1:0];
            held.match_score = sum[SUM_W-1:0];
            held.last = 1'b0;
            held.none_found = 1'b0;
            have_held = 1;
            found++;
          end
          if (!advance(0, t + 33'd1)) break;
        end
      end
    end
    if (!have_held) held.none_found = 1'b1;
    held.last = 1'b1;
    expected_matches.push_back(held);
  endfunction

  function automatic void apply_beat(in_item_t it);
    int unsigned k;
    int unsigned len;
    case (it.operation)
      OP_APPEND: begin
        k = it.list_index;
        if (k < MAX_LISTS) begin
          len = list_len[k];
          if (len < LIST_DEPTH && !(len > 0 && doc_mem[k][len-1] >= it.doc_number)) begin
            doc_mem[k][len] = it.doc_number;
            score_mem[k][len] = it.posting_score;
            list_len[k] = len + 1;
          end
        end
      end
      OP_RUN: begin
        predict_intersection(it.start_doc);
        intersections++;
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_LISTS; i++) begin
          list_len[i] = 0;
          cursor[i] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (expected_matches.size() == 0) begin
        $error("result beat with nothing expected: match_doc %0h", out_data.match_doc);
        fail_count++;
      end else begin
        oldest_match = expected_matches.pop_front();
        check_field("match_doc", oldest_match.match_doc, out_data.match_doc);
        check_field("match_score", oldest_match.match_score, out_data.match_score);
        check_field("last", oldest_match.last, out_data.last);
        check_field("none_found", oldest_match.none_found, out_data.none_found);
      end
    end
  end

  // counts cycles without any beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [1:0] idx, logic [31:0] doc,
                                         logic [15:0] score, logic [31:0] start);
    in_item_t it;
    it.operation = op;
    it.list_index = idx;
    it.doc_number = doc;
    it.posting_score = score;
    it.start_doc = start;
    return it;
  endfunction

  // run or clear beats carry random bits in the fields they do not use
  function automatic in_item_t run_beat(logic [31:0] start);
    return make_item(OP_RUN, 2'($urandom), $urandom, 16'($urandom), start);
  endfunction

  function automatic in_item_t clear_beat();
    return make_item(OP_CLEAR, 2'($urandom), $urandom, 16'($urandom), $urandom);
  endfunction

  function automatic in_item_t append_beat(logic [1:0] idx, logic [31:0] doc,
                                           logic [15:0] score);
    return make_item(OP_APPEND, idx, doc, score, $urandom);
  endfunction

  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    if (it.operation != OP_UNUSED) counted_beats++;
    apply_beat(it);
  endtask

  // sender holds off until every expected result has come and the core settles
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(bit is_write, logic [LCOUNT_W-1:0] value,
                            output logic [CFG_DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= LIST_COUNT_ADDR;
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_list_count(logic [LCOUNT_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    wait_drained();
    cfg_access(1'b1, value, rd);
    list_count_cfg = value;
    reg_writes++;
    cfg_access(1'b0, '0, rd);
    check_field("list_count readback", value, rd[LCOUNT_W-1:0]);
  endtask

  task automatic test_reset_state();
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, '0, rd);
    check_field("list_count after reset", LIST_COUNT_RESET, rd[LCOUNT_W-1:0]);
    // empty lists right after reset
    send_beat(run_beat(32'd0));
  endtask

  task automatic test_register_access();
    for (int v = 0; v < 8; v++) set_list_count(LCOUNT_W'(v));
    set_list_count(3'd2);
  endtask

  task automatic test_list_edges();
    send_beat(append_beat(2'd0, 32'd0, 16'hFFFF));
    send_beat(append_beat(2'd1, 32'd0, 16'hFFFF));
    send_beat(append_beat(2'd0, 32'd5, 16'd1));
    send_beat(append_beat(2'd1, 32'd7, 16'd2));
    // equal and smaller documents are dropped
    send_beat(append_beat(2'd1, 32'd7, 16'd9));
    send_beat(append_beat(2'd1, 32'd3, 16'd9));
    send_beat(append_beat(2'd0, 32'hFFFF_FFFF, 16'hFFFF));
    send_beat(append_beat(2'd1, 32'hFFFF_FFFF, 16'hFFFF));
    send_beat(make_item(OP_UNUSED, 2'd3, $urandom, 16'($urandom), $urandom));
    send_beat(run_beat(32'd0));
    send_beat(run_beat(32'd1));
    send_beat(run_beat(32'hFFFF_FFFF));
    send_beat(run_beat(32'd6));
    set_list_count(3'd1);
    send_beat(run_beat(32'd0));
    send_beat(run_beat(32'd6));
    set_list_count(3'd0);
    send_beat(run_beat(32'd5));
    // lists 2 and 3 still empty
    set_list_count(3'd4);
    send_beat(run_beat(32'd0));
    send_beat(append_beat(2'd2, 32'd0, 16'hFFFF));
    send_beat(append_beat(2'd3, 32'd0, 16'hFFFF));
    send_beat(append_beat(2'd2, 32'hFFFF_FFFF, 16'hFFFF));
    send_beat(append_beat(2'd3, 32'hFFFF_FFFF, 16'hFFFF));
    send_beat(run_beat(32'd0));
    set_list_count(3'd7);
    send_beat(run_beat(32'd0));
    set_list_count(3'd5);
    send_beat(clear_beat());
    send_beat(run_beat(32'd0));
  endtask

  // two full lists with identical documents give the longest run
  task automatic test_full_lists();
    set_list_count(3'd2);
    send_beat(clear_beat());
    for (int j = 0; j < LIST_DEPTH + 2; j++) begin
      send_beat(append_beat(2'd0, 32'(3 * j), 16'($urandom)));
      send_beat(append_beat(2'd1, 32'(3 * j), 16'($urandom)));
    end
    send_beat(run_beat(32'd0));
  endtask

  function automatic logic [15:0] random_score();
    return ($urandom_range(99) < 10) ? 16'hFFFF : 16'($urandom_range(65535));
  endfunction

  task automatic build_and_query();
    logic [32:0] base;
    logic [32:0] cand;
    logic [DOC_W-1:0] plan_doc [MAX_LISTS][LIST_DEPTH+2];
    int plan_len [MAX_LISTS];
    int plan_pos [MAX_LISTS];
    int stride;
    int want;
    int r;
    int k;
    int remaining;
    logic [DOC_W-1:0] prev;
    r = $urandom_range(99);
    set_list_count((r < 30) ? LCOUNT_W'($urandom_range(7)) : LCOUNT_W'($urandom_range(1, 4)));
    send_beat(clear_beat());
    case ($urandom_range(2))
      0: base = 33'($urandom_range(50));
      1: base = {1'b0, 32'($urandom)};
      default: base = DOC_TOP - 33'($urandom_range(60));
    endcase
    stride = $urandom_range(1, 3);
    remaining = 0;
    for (int i = 0; i < MAX_LISTS; i++) begin
      r = $urandom_range(99);
      if (r < 5) want = 0;
      else if (r < 85) want = $urandom_range(1, 8);
      else if (r < 96) want = $urandom_range(9, 24);
      else want = LIST_DEPTH + 2;
      plan_len[i] = 0;
      plan_pos[i] = 0;
      for (int j = 0; j < 240 && plan_len[i] < want; j++) begin
        cand = base + 33'(j * stride);
        if (cand > DOC_TOP) break;
        if ($urandom_range(99) < 70) begin
          plan_doc[i][plan_len[i]] = cand[DOC_W-1:0];
          plan_len[i]++;
        end
      end
      remaining += plan_len[i];
    end
    while (remaining > 0) begin
      k = $urandom_range(MAX_LISTS - 1);
      if (plan_pos[k] == plan_len[k]) continue;
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(2))
          0: if (plan_pos[k] > 0) begin
            prev = plan_doc[k][plan_pos[k]-1];
            if (prev != 0 && $urandom_range(1)) prev = prev - 1;
            send_beat(append_beat(2'(k), prev, random_score()));
          end
          1: send_beat(make_item(OP_UNUSED, 2'($urandom), $urandom, 16'($urandom), $urandom));
          default: send_beat(run_beat(base[DOC_W-1:0]));
        endcase
      end
      send_beat(append_beat(2'(k), plan_doc[k][plan_pos[k]], random_score()));
      plan_pos[k]++;
      remaining--;
    end
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(2))
        0: send_beat(run_beat(32'd0));
        1: begin
          cand = base + 33'($urandom_range(3 * 60));
          send_beat(run_beat((cand > DOC_TOP) ? 32'hFFFF_FFFF : cand[DOC_W-1:0]));
        end
        default: send_beat(run_beat($urandom));
      endcase
    end
  endtask

  task automatic random_noise();
    repeat ($urandom_range(3, 8))
      send_beat(make_item(2'($urandom), 2'($urandom), $urandom, 16'($urandom), $urandom));
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_beats);
    int first;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = counted_beats;
    while (counted_beats - first < n_beats) begin
      if ($urandom_range(99) < 80) build_and_query();
      else random_noise();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    beats_in = 0;
    counted_beats = 0;
    beats_out = 0;
    intersections = 0;
    reg_writes = 0;
    stall_cycles = 0;
    list_count_cfg = LIST_COUNT_RESET;
    for (int i = 0; i < MAX_LISTS; i++) begin
      list_len[i] = 0;
      cursor[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_access();
    test_list_edges();
    test_full_lists();
    test_random_traffic(0, 0, 70);
    test_random_traffic(64, 0, 70);
    test_random_traffic(0, 64, 70);
    test_random_traffic(8, 8, 70);
    wait_drained();

    if (expected_matches.size() != 0) begin
      $error("%0d expected results never arrived", expected_matches.size());
      fail_count++;
    end
    $display("covered %0d input beats, %0d intersections, %0d result beats",
             beats_in, intersections, beats_out);
    $display("list_count written %0d times, values 0 to 7, four idle and stall mixes",
             reg_writes);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
